FILE: rtl/ncb_pkg.sv
package ncb_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_HEIGHT    = 2048;
    localparam int ROW_W         = $clog2(MAX_HEIGHT);
    localparam int CFG_W         = 12;
    localparam int SUM_W         = 42;
    localparam int PIX_W         = 24;
    localparam int DIST_W        = 18;
    localparam int ADD_W         = 20;
    localparam int BETA_W        = 64;
    localparam int FRAC_SHIFT    = 31;
    localparam int CFG_IDX_W     = 1;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;
    localparam int OUT_DATA_W    = 112;
    localparam int IN_DATA_W     = 24;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_SUM,
        ST_LOAD,
        ST_DIV,
        ST_FIN
    } ncb_state_t;

    typedef struct packed {
        logic accept;
        logic calc;
        logic sum;
        logic load;
        logic step;
        logic fin;
    } ncb_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic div_last;
        logic out_free;
    } ncb_sts_t;

    function automatic logic [15:0] chan_sq(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d * d;
    endfunction

    function automatic logic [DIST_W-1:0] dist2(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
        logic [DIST_W-1:0] r;
        r = DIST_W'(chan_sq(a[23:16], b[23:16]))
          + DIST_W'(chan_sq(a[15:8], b[15:8]))
          + DIST_W'(chan_sq(a[7:0], b[7:0]));
        return r;
    endfunction

endpackage

FILE: rtl/ncb_div.sv
module ncb_div #(
    parameter int NUM_W = 57
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load,
    input  logic                     step,
    input  logic [NUM_W-1:0]         num,
    input  logic [ncb_pkg::SUM_W-1:0] den,
    output logic [NUM_W-1:0]         quo,
    output logic                     last
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
    localparam int SUM_W = ncb_pkg::SUM_W;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] nq_reg, nq_next;
    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [SUM_W:0]   trial;
    logic             qbit;

    // restoring divide, one quotient bit per step, numerator shifts out as quotient shifts in
    always_comb begin
        trial    = {rem_reg, nq_reg[NUM_W-1]};
        qbit     = (trial >= {1'b0, den});
        cnt_next = cnt_reg;
        nq_next  = nq_reg;
        rem_next = rem_reg;
        if (load) begin
            cnt_next = '0;
            nq_next  = num;
            rem_next = '0;
        end else if (step) begin
            cnt_next = cnt_reg + CNT_W'(1);
            nq_next  = {nq_reg[NUM_W-2:0], qbit};
            rem_next = qbit ? SUM_W'(trial - {1'b0, den}) : trial[SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
    end

    assign quo  = nq_reg;
    assign last = step && (cnt_reg == CNT_W'(NUM_W - 1));

endmodule

FILE: rtl/ncb_dp.sv
module ncb_dp #(
    parameter int MAX_WIDTH = ncb_pkg::MAX_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ncb_pkg::ncb_cmd_t               cmd,
    output ncb_pkg::ncb_sts_t               sts,
    input  logic                            cfg_we,
    input  logic [ncb_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [ncb_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic [ncb_pkg::PIX_W-1:0]       pixel_rgb,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ncb_pkg::BETA_W-1:0]      beta_q32,
    output logic [ncb_pkg::SUM_W-1:0]       contrast_sum
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int RW     = ncb_pkg::ROW_W;
    localparam int HW     = ncb_pkg::CFG_W;
    localparam int CNT_W  = WW + HW + 2;
    localparam int NUM_W  = CNT_W + ncb_pkg::FRAC_SHIFT;
    localparam int PIX_W  = ncb_pkg::PIX_W;
    localparam int SUM_W  = ncb_pkg::SUM_W;
    localparam int ADD_W  = ncb_pkg::ADD_W;
    localparam int BETA_W = ncb_pkg::BETA_W;
    localparam int CFG_W  = ncb_pkg::CFG_W;

    logic [CFG_W-1:0] fw_reg, fw_next;
    logic [CFG_W-1:0] fh_reg, fh_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [PIX_W-1:0] pix_reg, pix_next;
    logic [PIX_W-1:0] left_reg, left_next;
    logic [PIX_W-1:0] upleft_reg, upleft_next;
    logic [ADD_W-1:0] add_reg, add_next;
    logic             add_pend_reg, add_pend_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0] fsum_reg, fsum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             oval_reg, oval_next;
    logic [BETA_W-1:0] obeta_reg, obeta_next;
    logic [SUM_W-1:0] osum_reg, osum_next;

    logic [PIX_W-1:0] row_mem [MAX_WIDTH];
    logic [PIX_W-1:0] above_reg, upright_reg;

    logic [31:0]      w_wide, h_wide;
    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic             row_end, frame_end;
    logic [ADD_W-1:0] add_val;
    logic [SUM_W:0]   sum_ext;
    logic [WW+HW-1:0] area;
    logic [NUM_W-1:0] quo;
    logic             div_last;

    always_comb begin
        if (fw_reg == '0) begin
            w_wide = 32'd1;
        end else if (32'(fw_reg) > 32'(MAX_WIDTH)) begin
            w_wide = 32'(MAX_WIDTH);
        end else begin
            w_wide = 32'(fw_reg);
        end
        if (fh_reg == '0) begin
            h_wide = 32'd1;
        end else if (32'(fh_reg) > 32'(ncb_pkg::MAX_HEIGHT)) begin
            h_wide = 32'(ncb_pkg::MAX_HEIGHT);
        end else begin
            h_wide = 32'(fh_reg);
        end
    end

    assign w_eff     = w_wide[WW-1:0];
    assign h_eff     = h_wide[HW-1:0];
    assign row_end   = (32'(col_reg) + 32'd1) >= w_wide;
    assign frame_end = row_end && ((32'(row_reg) + 32'd1) >= h_wide);

    always_comb begin
        add_val = '0;
        if (col_reg != '0) begin
            add_val = add_val + ADD_W'(ncb_pkg::dist2(pix_reg, left_reg));
        end
        if (row_reg != '0 && col_reg != '0) begin
            add_val = add_val + ADD_W'(ncb_pkg::dist2(pix_reg, upleft_reg));
        end
        if (row_reg != '0) begin
            add_val = add_val + ADD_W'(ncb_pkg::dist2(pix_reg, above_reg));
        end
        if (row_reg != '0 && !row_end) begin
            add_val = add_val + ADD_W'(ncb_pkg::dist2(pix_reg, upright_reg));
        end
    end

    assign sum_ext = {1'b0, sum_reg} + (SUM_W + 1)'(add_reg);
    assign area    = (WW + HW)'(w_eff) * (WW + HW)'(h_eff);

    always_comb begin
        fw_next       = fw_reg;
        fh_next       = fh_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pix_next      = pix_reg;
        left_next     = left_reg;
        upleft_next   = upleft_reg;
        add_next      = add_reg;
        add_pend_next = cmd.calc;
        sum_next      = sum_reg;
        fsum_next     = fsum_reg;
        count_next    = count_reg;
        oval_next     = oval_reg && !out_ready;
        obeta_next    = obeta_reg;
        osum_next     = osum_reg;

        if (cfg_we) begin
            case (cfg_addr)
                ncb_pkg::REG_FRAME_WIDTH:  fw_next = cfg_wdata;
                ncb_pkg::REG_FRAME_HEIGHT: fh_next = cfg_wdata;
                default: ;
            endcase
        end

        if (cmd.accept) begin
            pix_next = pixel_rgb;
        end

        if (cmd.calc) begin
            add_next = add_val;
            if (row_end) begin
                col_next    = '0;
                row_next    = frame_end ? '0 : row_reg + RW'(1);
                left_next   = '0;
                upleft_next = '0;
            end else begin
                col_next    = col_reg + CW'(1);
                left_next   = pix_reg;
                upleft_next = above_reg;
            end
        end

        // saturating accumulate of the previous pixel's contribution
        if (add_pend_reg) begin
            sum_next = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        end

        if (cmd.sum) begin
            count_next = CNT_W'({area, 2'b00}) + CNT_W'(2)
                       - CNT_W'(w_eff) * CNT_W'(3) - CNT_W'(h_eff) * CNT_W'(3);
        end

        if (cmd.load) begin
            fsum_next = sum_reg;
            sum_next  = '0;
        end

        if (cmd.fin) begin
            oval_next  = 1'b1;
            obeta_next = (fsum_reg == '0) ? '0 : BETA_W'(quo);
            osum_next  = fsum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg       <= CFG_W'(ncb_pkg::WIDTH_RESET);
            fh_reg       <= CFG_W'(ncb_pkg::HEIGHT_RESET);
            col_reg      <= '0;
            row_reg      <= '0;
            add_pend_reg <= 1'b0;
            sum_reg      <= '0;
            oval_reg     <= 1'b0;
        end else begin
            fw_reg       <= fw_next;
            fh_reg       <= fh_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            add_pend_reg <= add_pend_next;
            sum_reg      <= sum_next;
            oval_reg     <= oval_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg    <= pix_next;
        left_reg   <= left_next;
        upleft_reg <= upleft_next;
        add_reg    <= add_next;
        fsum_reg   <= fsum_next;
        count_reg  <= count_next;
        obeta_reg  <= obeta_next;
        osum_reg   <= osum_next;
    end

    // line store: both reads issued with the accepted word, write of the same column in the next cycle
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            above_reg   <= row_mem[col_reg];
            upright_reg <= row_mem[col_reg + CW'(1)];
        end
        if (cmd.calc) begin
            row_mem[col_reg] <= pix_reg;
        end
    end

    ncb_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (cmd.load),
        .step    (cmd.step),
        .num     ({count_reg, ncb_pkg::FRAC_SHIFT'(0)}),
        .den     (fsum_reg),
        .quo     (quo),
        .last    (div_last)
    );

    assign sts.frame_end = frame_end;
    assign sts.div_last  = div_last;
    assign sts.out_free  = !oval_reg || out_ready;

    assign out_valid    = oval_reg;
    assign beta_q32     = obeta_reg;
    assign contrast_sum = osum_reg;

endmodule

FILE: rtl/ncb_ctrl.sv
module ncb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ncb_pkg::ncb_sts_t sts,
    output ncb_pkg::ncb_cmd_t cmd
);

    ncb_pkg::ncb_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ncb_pkg::ST_IDLE: begin
                if (in_valid) state_next = ncb_pkg::ST_CALC;
            end
            ncb_pkg::ST_CALC: begin
                state_next = sts.frame_end ? ncb_pkg::ST_SUM : ncb_pkg::ST_IDLE;
            end
            ncb_pkg::ST_SUM:  state_next = ncb_pkg::ST_LOAD;
            ncb_pkg::ST_LOAD: state_next = ncb_pkg::ST_DIV;
            ncb_pkg::ST_DIV: begin
                if (sts.div_last) state_next = ncb_pkg::ST_FIN;
            end
            ncb_pkg::ST_FIN: begin
                if (sts.out_free) state_next = ncb_pkg::ST_IDLE;
            end
            default: state_next = ncb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ncb_pkg::ST_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ncb_pkg::ST_CALC: cmd.calc = 1'b1;
            ncb_pkg::ST_SUM:  cmd.sum  = 1'b1;
            ncb_pkg::ST_LOAD: cmd.load = 1'b1;
            ncb_pkg::ST_DIV:  cmd.step = 1'b1;
            ncb_pkg::ST_FIN:  cmd.fin  = sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ncb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/neighbor_contrast_beta_unit.sv
// channel   dir  ports                      word
// s_        in   s_tvalid s_tready s_tdata  pixel_rgb
// m_        out  m_tvalid m_tready m_tdata  beta_q32, contrast_sum
// cfg_      in   cfg_we cfg_addr cfg_wdata  frame_width (0), frame_height (1)
//
// a pixel: line store read with the accept, distances in the next cycle, s_tready low meanwhile
// the last pixel of a frame is followed by the sum and load states and the bit-serial beta
// divider, which steps through the divide state before the finish state
// aresetn clears position, sum and registers to 640 x 480; the line store is not cleared
// pixels are held off from a frame end until its result moves into the output register,
// which waits for m_tready only while the previous result is still unaccepted
module neighbor_contrast_beta_unit #(
    parameter int MAX_WIDTH = ncb_pkg::MAX_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ncb_pkg::IN_DATA_W-1:0]    s_tdata,   // pixel_rgb[23:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ncb_pkg::OUT_DATA_W-1:0]   m_tdata,   // beta_q32[63:0], contrast_sum[105:64]
    input  logic                             cfg_we,
    input  logic [ncb_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [ncb_pkg::CFG_W-1:0]        cfg_wdata
);

    ncb_pkg::ncb_cmd_t cmd;
    ncb_pkg::ncb_sts_t sts;

    logic [ncb_pkg::BETA_W-1:0] beta_q32;
    logic [ncb_pkg::SUM_W-1:0]  contrast_sum;

    ncb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ncb_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .pixel_rgb    (s_tdata[ncb_pkg::PIX_W-1:0]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .beta_q32     (beta_q32),
        .contrast_sum (contrast_sum)
    );

    assign m_tdata = {
        (ncb_pkg::OUT_DATA_W - ncb_pkg::BETA_W - ncb_pkg::SUM_W)'(0),
        contrast_sum,
        beta_q32
    };

endmodule

FILE: test/neighbor_contrast_beta_unit_checker.sv
`timescale 1ns / 100ps

module neighbor_contrast_beta_unit_checker #(
    parameter int MAX_WIDTH = ncb_pkg::MAX_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ncb_pkg::IN_DATA_W-1:0]  s_tdata,    // pixel_rgb[23:0]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ncb_pkg::OUT_DATA_W-1:0] m_tdata,    // beta_q32[63:0], contrast_sum[105:64]
    input  logic                           cfg_we,
    input  logic [ncb_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [ncb_pkg::CFG_W-1:0]      cfg_wdata,
    output int                             fail_count,
    output int                             pending,
    output bit                             frame_idle
);
    import ncb_pkg::*;

    localparam logic [63:0] SUM_CEIL = (64'd1 << SUM_W) - 64'd1;

    typedef struct packed {
        logic [BETA_W-1:0] beta_q32;
        logic [SUM_W-1:0]  contrast_sum;
    } frame_stats_t;

    frame_stats_t     frame_stats_q[$];
    logic [PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [PIX_W-1:0] left_px;
    logic [PIX_W-1:0] upleft_px;
    int unsigned      col;
    int unsigned      row;
    logic [63:0]      contrast_acc;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    function automatic int unsigned color_dist(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
        int unsigned total;
        int unsigned d;
        total = 0;
        for (int c = 0; c < 3; c++) begin
            if (a[c*8 +: 8] > b[c*8 +: 8])
                d = a[c*8 +: 8] - b[c*8 +: 8];
            else
                d = b[c*8 +: 8] - a[c*8 +: 8];
            total += d * d;
        end
        return total;
    endfunction

    // zero acts as one, anything past the cap acts as the cap
    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned cap);
        if (v == 0) return 1;
        if (v > cap) return cap;
        return v;
    endfunction

    task automatic take_pixel(input logic [PIX_W-1:0] px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      idx;
        logic [PIX_W-1:0] above;
        logic [63:0]      add;
        logic [63:0]      span;
        bit               row_end;
        bit               frame_end;
        frame_stats_t     stats;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        idx = (col < MAX_WIDTH) ? col : MAX_WIDTH - 1;
        above = line_mem[idx];
        row_end = (col + 1 >= w);
        add = 0;
        if (col > 0) add += color_dist(px, left_px);
        if (row > 0 && col > 0) add += color_dist(px, upleft_px);
        if (row > 0) add += color_dist(px, above);
        if (row > 0 && !row_end && idx + 1 < MAX_WIDTH) add += color_dist(px, line_mem[idx + 1]);
        contrast_acc += add;
        if (contrast_acc > SUM_CEIL) contrast_acc = SUM_CEIL;

        upleft_px = above;
        line_mem[idx] = px;
        left_px = px;

        frame_end = row_end && (row + 1 >= h);
        if (row_end) begin
            col = 0;
            row = frame_end ? 0 : row + 1;
            left_px = '0;
            upleft_px = '0;
        end else begin
            col = col + 1;
        end

        if (frame_end) begin
            // pair count 4WH - 3W - 3H + 2, beta = count / (2 * sum) in Q32.32
            span = 64'(4 * w * h) + 64'd2 - 64'(3 * w) - 64'(3 * h);
            stats.beta_q32 = (contrast_acc == 0) ? '0 : (span << FRAC_SHIFT) / contrast_acc;
            stats.contrast_sum = contrast_acc[SUM_W-1:0];
            frame_stats_q = {frame_stats_q, stats};
            contrast_acc = 0;
        end
    endtask

    always @(posedge aclk) begin : watch
        frame_stats_t      want;
        logic [BETA_W-1:0] got_beta;
        logic [SUM_W-1:0]  got_sum;
        if (!aresetn) begin
            for (int i = 0; i < MAX_WIDTH; i++) line_mem[i] = '0;
            left_px = '0;
            upleft_px = '0;
            col = 0;
            row = 0;
            contrast_acc = 0;
            width_reg = CFG_W'(WIDTH_RESET);
            height_reg = CFG_W'(HEIGHT_RESET);
            frame_stats_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_FRAME_WIDTH) width_reg = cfg_wdata;
                else if (cfg_addr == REG_FRAME_HEIGHT) height_reg = cfg_wdata;
            end
            if (s_tvalid && s_tready) take_pixel(s_tdata);
            if (m_tvalid && m_tready) begin
                got_beta = m_tdata[BETA_W-1:0];
                got_sum = m_tdata[BETA_W +: SUM_W];
                if (frame_stats_q.size() == 0) begin
                    $error("result word with no frame pending: beta_q32 %0h contrast_sum %0h",
                           got_beta, got_sum);
                    fail_count++;
                end else begin
                    want = frame_stats_q.pop_front();
                    if (got_beta !== want.beta_q32) begin
                        $error("beta_q32: expected %0h, actual %0h", want.beta_q32, got_beta);
                        fail_count++;
                    end
                    if (got_sum !== want.contrast_sum) begin
                        $error("contrast_sum: expected %0h, actual %0h",
                               want.contrast_sum, got_sum);
                        fail_count++;
                    end
                end
            end
        end
        pending = frame_stats_q.size();
        frame_idle = (col == 0 && row == 0);
    end

endmodule

FILE: test/neighbor_contrast_beta_unit_tb.sv
`timescale 1ns / 100ps

module neighbor_contrast_beta_unit_tb;
    import ncb_pkg::*;

    localparam int DRAIN_CYCLES  = 100;
    localparam int END_WAIT      = 20000;
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int RANDOM_PIXELS = 1400;
    localparam int EXTREME_CUT   = 30;

    typedef enum int {
        PIX_RANDOM,
        PIX_EXTREME,
        PIX_FLAT,
        PIX_NOISY
    } pix_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;    // pixel_rgb[23:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;    // beta_q32[63:0], contrast_sum[105:64]
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;

    int          fail_count;
    int          pending;
    bit          frame_idle;
    bit          no_idle;
    int unsigned cur_w;
    int unsigned cur_h;
    int          cycle_count;

    neighbor_contrast_beta_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    neighbor_contrast_beta_unit_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .frame_idle (frame_idle)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("neighbor_contrast_beta_unit regression: fail");
            $finish;
        end
    end

    // result side backpressure: runs of ready and stall, mostly short stalls
    initial begin : sink
        int run;
        int p;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (no_idle || $urandom_range(0, 1)) begin
                m_tready <= 1'b1;
                run = no_idle ? 1 : $urandom_range(1, 30);
            end else begin
                m_tready <= 1'b0;
                p = $urandom_range(0, 99);
                if (p < 85) run = $urandom_range(1, 3);
                else if (p < 97) run = $urandom_range(4, 20);
                else run = $urandom_range(50, 150);
            end
            repeat (run - 1) @(negedge aclk);
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PIX_W-1:0] make_pixel(input pix_mode_t mode,
                                                    input logic [PIX_W-1:0] base);
        logic [PIX_W-1:0] px;
        px = base;
        case (mode)
            PIX_RANDOM: begin
                px = PIX_W'($urandom);
            end
            PIX_EXTREME: begin
                for (int c = 0; c < 3; c++) px[c*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            PIX_NOISY: begin
                for (int c = 0; c < 3; c++)
                    px[c*8 +: 8] = base[c*8 +: 8] + 8'($urandom_range(0, 6)) - 8'd3;
            end
            default: begin
                px = base;
            end
        endcase
        return px;
    endfunction

    // all tasks start and end at a falling edge
    task automatic push_pixel(input logic [PIX_W-1:0] px);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // stop sending, let every owed result out, then let the pipeline go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= CFG_W'(val);
        if (idx == REG_FRAME_WIDTH) cur_w = val;
        else if (idx == REG_FRAME_HEIGHT) cur_h = val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        settle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // sends pixels until the frame closes; optionally rewrites a register mid-frame
    task automatic send_frame(input pix_mode_t mode, input int cut_at,
                              input logic [CFG_IDX_W-1:0] cut_reg, input int unsigned cut_val,
                              output int n);
        logic [PIX_W-1:0] base;
        base = PIX_W'($urandom);
        n = 0;
        do begin
            if (n == cut_at) begin
                settle();
                write_reg(cut_reg, cut_val);
            end
            push_pixel(make_pixel(mode, base));
            n++;
        end while (!frame_idle);
    endtask

    initial begin : stimulus
        int                   sent;
        int                   n;
        int                   cut_at;
        int                   r;
        int unsigned          w;
        int unsigned          h;
        int unsigned          area;
        int unsigned          cut_val;
        logic [CFG_IDX_W-1:0] cut_reg;
        pix_mode_t            mode;
        bit                   first;
        int unsigned          big_w [4];
        int unsigned          big_h [4];
        logic [CFG_IDX_W-1:0] big_reg [4];
        int unsigned          big_val [4];

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = REG_FRAME_WIDTH;
        cfg_wdata = '0;
        no_idle = 1'b1;
        cur_w = WIDTH_RESET;
        cur_h = HEIGHT_RESET;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // single pixel frames: no pairs, no sum
        set_frame(1, 1);
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);
        // largest possible distances horizontally and vertically, zero distance on the diagonals
        set_frame(2, 2);
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);
        push_pixel(24'hFFFFFF);
        push_pixel(24'h000000);
        // flat frame, zero contrast gives zero beta
        set_frame(3, 2);
        repeat (6) push_pixel(24'h5A3C96);
        // zero width and zero height act as one
        set_frame(0, 3);
        push_pixel(24'hFF0000);
        push_pixel(24'h00FF00);
        push_pixel(24'h0000FF);
        set_frame(4, 0);
        push_pixel(24'h800000);
        push_pixel(24'h008000);
        push_pixel(24'h000080);
        push_pixel(24'h7F7F7F);
        // height lowered below the current row mid-frame: frame ends at this row
        set_frame(3, 5);
        repeat (4) push_pixel(PIX_W'($urandom));
        settle();
        write_reg(REG_FRAME_HEIGHT, 1);
        repeat (2) push_pixel(PIX_W'($urandom));
        // width lowered below the current column mid-frame: row ends on the next word
        set_frame(4, 2);
        repeat (6) push_pixel(PIX_W'($urandom));
        settle();
        write_reg(REG_FRAME_WIDTH, 2);
        push_pixel(PIX_W'($urandom));

        // size extremes, including register values past the limits, closed early mid-frame
        no_idle = 1'b0;
        big_w = '{4095, 2048, 1, 2};
        big_h = '{2, 1, 4095, 2048};
        big_reg = '{REG_FRAME_WIDTH, REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_FRAME_HEIGHT};
        big_val = '{3, 1, 1, 0};
        for (int i = 0; i < 4; i++) begin
            set_frame(big_w[i], big_h[i]);
            send_frame(PIX_RANDOM, EXTREME_CUT, big_reg[i], big_val[i], n);
        end

        sent = 0;
        first = 1'b1;
        while (sent < RANDOM_PIXELS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if (first || $urandom_range(0, 4) < 3) begin
                r = $urandom_range(0, 99);
                if (r < 3) w = 0;
                else if (r < 70) w = $urandom_range(1, 8);
                else if (r < 95) w = $urandom_range(9, 40);
                else w = $urandom_range(41, 200);
                r = $urandom_range(0, 99);
                if (r < 3) h = 0;
                else if (r < 80) h = $urandom_range(1, 6);
                else h = $urandom_range(7, 20);
                if (w > 40 && h > 3) h = $urandom_range(1, 3);
                set_frame(w, h);
            end
            first = 1'b0;
            mode = pix_mode_t'($urandom_range(0, 3));
            cut_at = -1;
            cut_reg = REG_FRAME_HEIGHT;
            cut_val = 0;
            area = ((cur_w == 0) ? 1 : cur_w) * ((cur_h == 0) ? 1 : cur_h);
            if (area > 1 && $urandom_range(0, 7) == 0) begin
                cut_at = $urandom_range(1, area - 1);
                // width never grows mid-frame so the line store is never read unwritten
                if ($urandom_range(0, 1)) begin
                    cut_reg = REG_FRAME_WIDTH;
                    cut_val = $urandom_range(0, (cur_w == 0) ? 1 : cur_w);
                end else begin
                    cut_val = $urandom_range(0, 8);
                end
            end
            send_frame(mode, cut_at, cut_reg, cut_val, n);
            sent += n;
        end

        s_tvalid <= 1'b0;
        n = 0;
        while (pending != 0 && n < END_WAIT) begin
            @(negedge aclk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (pending != 0) $error("%0d frame results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("neighbor_contrast_beta_unit regression: pass");
        end else begin
            $display("neighbor_contrast_beta_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ncb_pkg.sv
rtl/ncb_div.sv
rtl/ncb_dp.sv
rtl/ncb_ctrl.sv
rtl/neighbor_contrast_beta_unit.sv
test/neighbor_contrast_beta_unit_checker.sv
test/neighbor_contrast_beta_unit_tb.sv
